### rtl/wps_pkg.sv
// Shared types and constants for the WAV PCM stream parser.
// No dependencies; imported by wav_pcm_stream_parser.
package wps_pkg;

    typedef logic [1:0] kind_t;
    typedef logic [2:0] err_t;

    // result kinds
    localparam kind_t KIND_HEADER = 2'd0;
    localparam kind_t KIND_SAMPLE = 2'd1;
    localparam kind_t KIND_ERROR  = 2'd2;

    // error codes
    localparam err_t ERR_RIFF      = 3'd0;
    localparam err_t ERR_WAVE      = 3'd1;
    localparam err_t ERR_FMT_TAG   = 3'd2;
    localparam err_t ERR_FMT_SIZE  = 3'd3;
    localparam err_t ERR_FORMAT_ID = 3'd4;
    localparam err_t ERR_WIDTH     = 3'd5;
    localparam err_t ERR_TRUNC     = 3'd6;

    // chunk tags as little-endian words, first byte in the low bits
    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6d66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    localparam logic [31:0] FMT_CHUNK_SIZE = 32'd16;
    localparam logic [31:0] PCM_FORMAT_ID  = 32'd1;

endpackage

### rtl/wav_pcm_stream_parser.sv
// WAV (RIFF/PCM) byte-stream parser, top level.
// Depends on wps_pkg for result kinds, error codes and chunk tags.
//
//   channel  | direction | handshake           | payload
//   ---------+-----------+---------------------+---------------------------------------
//   in       | sink      | in_valid / in_stall | byte_value, end_of_file
//   out      | source    | out_valid/out_stall | result_kind, sample_value, sample_rate,
//            |           |                     | bits_per_sample, channel_count,
//            |           |                     | data_byte_count, frame_number,
//            |           |                     | error_code, last_sample
//
// One byte per cycle sustained while the output is not stalled: a request is held in the input
// register, is parsed in a single pass and its result, if any, lands in the output register.
// A result passes from the input register to the output register, where it can be taken
// once out_stall is low.
// Reset (rst_n low, asynchronous) returns the parser to the RIFF tag and clears both
// pipeline registers. A stalled output holds the input register, which then raises
// in_stall; bytes that give no result still wait for a free output slot.
module wav_pcm_stream_parser #(
    parameter int MAX_SAMPLE_BYTES = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [7:0]          byte_value,
    input  logic                end_of_file,
    output logic                out_valid,
    input  logic                out_stall,
    output wps_pkg::kind_t      result_kind,
    output logic signed [31:0]  sample_value,
    output logic [31:0]         sample_rate,
    output logic [7:0]          bits_per_sample,
    output logic [7:0]          channel_count,
    output logic [31:0]         data_byte_count,
    output logic [31:0]         frame_number,
    output wps_pkg::err_t       error_code,
    output logic                last_sample
);
    import wps_pkg::*;

    localparam int ACC_W = 8 * MAX_SAMPLE_BYTES;

    // parse phases
    localparam logic [4:0] PH_RIFF   = 5'd0;
    localparam logic [4:0] PH_RSIZE  = 5'd1;
    localparam logic [4:0] PH_WAVE   = 5'd2;
    localparam logic [4:0] PH_FMT    = 5'd3;
    localparam logic [4:0] PH_FSIZE  = 5'd4;
    localparam logic [4:0] PH_FORMAT = 5'd5;
    localparam logic [4:0] PH_CHAN   = 5'd6;
    localparam logic [4:0] PH_RATE   = 5'd7;
    localparam logic [4:0] PH_SKIP6  = 5'd8;
    localparam logic [4:0] PH_BITS   = 5'd9;
    localparam logic [4:0] PH_TAG    = 5'd10;
    localparam logic [4:0] PH_CSIZE  = 5'd11;
    localparam logic [4:0] PH_CSKIP  = 5'd12;
    localparam logic [4:0] PH_DSIZE  = 5'd13;
    localparam logic [4:0] PH_DATA   = 5'd14;

    // bytes in the header field of each phase
    function automatic logic [2:0] field_len(input logic [4:0] ph);
        logic [2:0] len;
        unique case (ph)
            PH_FORMAT, PH_CHAN, PH_BITS: len = 3'd2;
            PH_SKIP6:                    len = 3'd6;
            PH_CSKIP, PH_DATA:           len = 3'd0;
            default:                     len = 3'd4;
        endcase
        return len;
    endfunction

    // input register
    logic        s1_valid_reg;
    logic [7:0]  s1_byte_reg;
    logic        s1_eof_reg;

    // parser state
    logic [4:0]       phase_reg, phase_next;
    logic [2:0]       fbc_reg, fbc_next;
    logic [31:0]      tag_reg, tag_next;
    logic [31:0]      rate_reg, rate_next;
    logic [7:0]       bits_reg, bits_next;
    logic [7:0]       chan_reg, chan_next;
    logic [31:0]      skip_reg, skip_next;
    logic [31:0]      data_reg, data_next;
    logic [ACC_W-1:0] acc_reg, acc_next;
    logic [10:0]      bif_reg, bif_next;
    logic [31:0]      frame_reg, frame_next;
    logic             halted_reg, halted_next;

    // output register
    logic               out_valid_reg;
    kind_t              kind_reg;
    logic signed [31:0] sval_reg;
    logic [31:0]        rate_out_reg;
    logic [7:0]         bits_out_reg;
    logic [7:0]         chan_out_reg;
    logic [31:0]        dcount_out_reg;
    logic [31:0]        fnum_out_reg;
    err_t               err_out_reg;
    logic               last_out_reg;

    // single-pass results
    logic             has_res;
    kind_t            res_kind;
    err_t             res_err;
    logic [31:0]      res_sval;
    logic [31:0]      res_fnum;
    logic             res_last;
    logic [31:0]      shifted;
    logic [31:0]      field_val;
    logic [2:0]       len;
    logic [2:0]       fbc_inc;
    logic [10:0]      bif_inc;
    logic [2:0]       q;
    logic [10:0]      fb;
    logic [ACC_W-1:0] acc_cur;
    logic [31:0]      acc_ext;
    logic             sign_bit;

    logic out_free;
    logic fire;

    // pipeline flow
    assign out_free = !out_valid_reg || !out_stall;
    assign fire     = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;

    // sample and frame sizes
    assign q  = bits_reg[5:3];
    assign fb = 11'(q) * 11'(chan_reg);

    // field value from the shift register
    assign shifted = {s1_byte_reg, tag_reg[31:8]};
    assign len     = field_len(phase_reg);
    assign fbc_inc = fbc_reg + 3'd1;
    assign bif_inc = bif_reg + 11'd1;

    always_comb
    begin
        case (len)
            3'd4:    field_val = shifted;
            3'd2:    field_val = {16'd0, shifted[31:16]};
            default: field_val = 32'd0;
        endcase
    end

    // first-channel byte lanes
    always_comb
    begin
        acc_cur = acc_reg;
        for (int k = 0; k < MAX_SAMPLE_BYTES; k++)
        begin
            if (bif_reg == 11'(k) && 11'(k) < 11'(q))
            begin
                acc_cur[8*k +: 8] = s1_byte_reg;
            end
        end
    end

    // sign extension by sample width
    assign acc_ext = 32'(acc_cur);

    always_comb
    begin
        sign_bit = 1'b0;
        for (int k = 1; k <= MAX_SAMPLE_BYTES; k++)
        begin
            if (q == 3'(k))
            begin
                sign_bit = acc_ext[8*k-1];
            end
        end
    end

    // parse step for one byte
    always_comb
    begin
        phase_next  = phase_reg;
        fbc_next    = fbc_reg;
        tag_next    = tag_reg;
        rate_next   = rate_reg;
        bits_next   = bits_reg;
        chan_next   = chan_reg;
        skip_next   = skip_reg;
        data_next   = data_reg;
        acc_next    = acc_reg;
        bif_next    = bif_reg;
        frame_next  = frame_reg;
        halted_next = halted_reg;
        has_res     = 1'b0;
        res_kind    = KIND_HEADER;
        res_err     = ERR_RIFF;
        res_sval    = 32'd0;
        res_fnum    = 32'd0;
        res_last    = 1'b0;

        if (!halted_reg)
        begin
            if (phase_reg == PH_CSKIP)
            begin
                skip_next = skip_reg - 32'd1;
                if (skip_next == 32'd0)
                begin
                    phase_next = PH_TAG;
                end
            end
            else if (phase_reg == PH_DATA)
            begin
                acc_next  = acc_cur;
                data_next = data_reg - 32'd1;
                bif_next  = bif_inc;
                if (bif_inc >= fb)
                begin
                    has_res  = 1'b1;
                    res_kind = KIND_SAMPLE;
                    for (int i = 0; i < 32; i++)
                    begin
                        res_sval[i] = (6'(i) < {q, 3'b000}) ? acc_ext[i] : sign_bit;
                    end
                    res_fnum   = frame_reg;
                    res_last   = data_next < 32'(fb);
                    frame_next = frame_reg + 32'd1;
                    bif_next   = 11'd0;
                    acc_next   = '0;
                end
                if (data_next == 32'd0)
                begin
                    halted_next = 1'b1;
                end
            end
            else if (phase_reg < PH_DATA)
            begin
                tag_next = shifted;
                fbc_next = fbc_inc;
                if (fbc_inc >= len)
                begin
                    fbc_next = 3'd0;
                    unique case (phase_reg)
                        PH_RIFF:
                        begin
                            if (field_val != TAG_RIFF)
                            begin
                                has_res = 1'b1; res_kind = KIND_ERROR; res_err = ERR_RIFF;
                            end
                            else phase_next = PH_RSIZE;
                        end
                        PH_RSIZE: phase_next = PH_WAVE;
                        PH_WAVE:
                        begin
                            if (field_val != TAG_WAVE)
                            begin
                                has_res = 1'b1; res_kind = KIND_ERROR; res_err = ERR_WAVE;
                            end
                            else phase_next = PH_FMT;
                        end
                        PH_FMT:
                        begin
                            if (field_val != TAG_FMT)
                            begin
                                has_res = 1'b1; res_kind = KIND_ERROR;
                                res_err = ERR_FMT_TAG;
                            end
                            else phase_next = PH_FSIZE;
                        end
                        PH_FSIZE:
                        begin
                            if (field_val != FMT_CHUNK_SIZE)
                            begin
                                has_res = 1'b1; res_kind = KIND_ERROR;
                                res_err = ERR_FMT_SIZE;
                            end
                            else phase_next = PH_FORMAT;
                        end
                        PH_FORMAT:
                        begin
                            if (field_val != PCM_FORMAT_ID)
                            begin
                                has_res = 1'b1; res_kind = KIND_ERROR;
                                res_err = ERR_FORMAT_ID;
                            end
                            else phase_next = PH_CHAN;
                        end
                        PH_CHAN:
                        begin
                            chan_next  = field_val[7:0];
                            phase_next = PH_RATE;
                        end
                        PH_RATE:
                        begin
                            rate_next  = field_val;
                            phase_next = PH_SKIP6;
                        end
                        PH_SKIP6: phase_next = PH_BITS;
                        PH_BITS:
                        begin
                            bits_next = field_val[7:0];
                            if (bits_next[2:0] != 3'd0 || bits_next[7:3] == 5'd0 ||
                                bits_next[7:3] > 5'(MAX_SAMPLE_BYTES) || chan_reg == 8'd0)
                            begin
                                has_res = 1'b1; res_kind = KIND_ERROR; res_err = ERR_WIDTH;
                            end
                            else phase_next = PH_TAG;
                        end
                        PH_TAG:
                        begin
                            phase_next = (field_val == TAG_DATA) ? PH_DSIZE : PH_CSIZE;
                        end
                        PH_CSIZE:
                        begin
                            skip_next  = field_val;
                            phase_next = (field_val == 32'd0) ? PH_TAG : PH_CSKIP;
                        end
                        PH_DSIZE:
                        begin
                            data_next  = field_val;
                            bif_next   = 11'd0;
                            acc_next   = '0;
                            frame_next = 32'd0;
                            has_res    = 1'b1;
                            res_kind   = KIND_HEADER;
                            phase_next = PH_DATA;
                            if (field_val == 32'd0)
                            begin
                                halted_next = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            else
            begin
                halted_next = 1'b1;
            end

            // an error stops the parser
            if (has_res && res_kind == KIND_ERROR)
            begin
                halted_next = 1'b1;
            end

            // end of file before completion
            if (s1_eof_reg && !halted_next)
            begin
                has_res     = 1'b1;
                res_kind    = KIND_ERROR;
                res_err     = ERR_TRUNC;
                halted_next = 1'b1;
            end
        end
    end

    // input register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    // input register payload
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_byte_reg <= byte_value;
            s1_eof_reg  <= end_of_file;
        end
    end

    // parser state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_RIFF;
            fbc_reg    <= 3'd0;
            tag_reg    <= 32'd0;
            rate_reg   <= 32'd0;
            bits_reg   <= 8'd0;
            chan_reg   <= 8'd0;
            skip_reg   <= 32'd0;
            data_reg   <= 32'd0;
            acc_reg    <= '0;
            bif_reg    <= 11'd0;
            frame_reg  <= 32'd0;
            halted_reg <= 1'b0;
        end
        else if (fire)
        begin
            phase_reg  <= phase_next;
            fbc_reg    <= fbc_next;
            tag_reg    <= tag_next;
            rate_reg   <= rate_next;
            bits_reg   <= bits_next;
            chan_reg   <= chan_next;
            skip_reg   <= skip_next;
            data_reg   <= data_next;
            acc_reg    <= acc_next;
            bif_reg    <= bif_next;
            frame_reg  <= frame_next;
            halted_reg <= halted_next;
        end
    end

    // output register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= fire && has_res;
        end
    end

    // output register payload, fields of other kinds forced to zero
    always_ff @(posedge clk)
    begin
        if (fire && has_res)
        begin
            kind_reg       <= res_kind;
            sval_reg       <= (res_kind == KIND_SAMPLE) ? res_sval : 32'sd0;
            fnum_out_reg   <= (res_kind == KIND_SAMPLE) ? res_fnum : 32'd0;
            last_out_reg   <= (res_kind == KIND_SAMPLE) && res_last;
            rate_out_reg   <= (res_kind == KIND_HEADER) ? rate_next : 32'd0;
            bits_out_reg   <= (res_kind == KIND_HEADER) ? bits_next : 8'd0;
            chan_out_reg   <= (res_kind == KIND_HEADER) ? chan_next : 8'd0;
            dcount_out_reg <= (res_kind == KIND_HEADER) ? data_next : 32'd0;
            err_out_reg    <= (res_kind == KIND_ERROR) ? res_err : ERR_RIFF;
        end
    end

    assign out_valid       = out_valid_reg;
    assign result_kind     = kind_reg;
    assign sample_value    = sval_reg;
    assign sample_rate     = rate_out_reg;
    assign bits_per_sample = bits_out_reg;
    assign channel_count   = chan_out_reg;
    assign data_byte_count = dcount_out_reg;
    assign frame_number    = fnum_out_reg;
    assign error_code      = err_out_reg;
    assign last_sample     = last_out_reg;

endmodule

### verif/tb_wav_pcm_stream_parser.sv
`timescale 1ns / 1ps
// Testbench for wav_pcm_stream_parser: feeds one WAV file byte by byte and checks every result
// against a behavioral parser kept in this file.
// Depends on wps_pkg for result kinds, error codes and chunk tags.
module tb_wav_pcm_stream_parser;

    import wps_pkg::*;

    localparam int MAX_SAMPLE_BYTES = 4;
    localparam int CYCLE_LIMIT      = 200000;
    localparam int DRAIN_CYCLES     = 10;

    // parser position inside the file
    typedef enum logic [3:0] {
        P_RIFF_TAG,
        P_RIFF_SIZE,
        P_WAVE_TAG,
        P_FMT_TAG,
        P_FMT_SIZE,
        P_FORMAT_ID,
        P_CHANNELS,
        P_RATE,
        P_RATE_SKIP,
        P_BITS,
        P_CHUNK_TAG,
        P_CHUNK_SIZE,
        P_CHUNK_SKIP,
        P_DATA_SIZE,
        P_DATA
    } parse_phase_e;

    typedef struct {
        kind_t       kind;
        logic [31:0] sample;
        logic [31:0] rate;
        logic [7:0]  bits;
        logic [7:0]  chans;
        logic [31:0] data_bytes;
        logic [31:0] frame;
        err_t        err;
        logic        last;
    } wav_result_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [7:0]         byte_value;
    logic               end_of_file;
    logic               out_valid;
    logic               out_stall;
    kind_t              result_kind;
    logic signed [31:0] sample_value;
    logic [31:0]        sample_rate;
    logic [7:0]         bits_per_sample;
    logic [7:0]         channel_count;
    logic [31:0]        data_byte_count;
    logic [31:0]        frame_number;
    err_t               error_code;
    logic               last_sample;

    wav_result_t parsed_results[$];
    int          mismatch_count;
    int          cycle_count;
    int          send_idle_pct;
    int          stall_pct;

    // file format chosen for this run
    int unsigned sample_size;
    int unsigned channel_total;
    int unsigned frame_size;
    int unsigned frames_per_phase;

    // behavioral parser state
    parse_phase_e pr_phase;
    int unsigned  pr_count;
    logic [31:0]  pr_shift;
    logic [31:0]  pr_rate;
    logic [7:0]   pr_bits;
    logic [7:0]   pr_chans;
    logic [31:0]  pr_skip_left;
    logic [31:0]  pr_data_left;
    logic [31:0]  pr_accum;
    int unsigned  pr_frame_byte;
    logic [31:0]  pr_frame_idx;
    logic         pr_halted;

    wav_pcm_stream_parser #(
        .MAX_SAMPLE_BYTES(MAX_SAMPLE_BYTES)
    ) i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .byte_value     (byte_value),
        .end_of_file    (end_of_file),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .result_kind    (result_kind),
        .sample_value   (sample_value),
        .sample_rate    (sample_rate),
        .bits_per_sample(bits_per_sample),
        .channel_count  (channel_count),
        .data_byte_count(data_byte_count),
        .frame_number   (frame_number),
        .error_code     (error_code),
        .last_sample    (last_sample)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run time guard
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d results still awaited", $time, parsed_results.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // receiver back-pressure
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // number of bytes in each header field
    function automatic int unsigned field_length(parse_phase_e ph);
        case (ph)
            P_FORMAT_ID, P_CHANNELS, P_BITS: return 2;
            P_RATE_SKIP:                     return 6;
            P_CHUNK_SKIP, P_DATA:            return 0;
            default:                         return 4;
        endcase
    endfunction

    function automatic logic [31:0] extend_sample(logic [31:0] raw, int unsigned nbytes);
        logic [31:0] mask;
        if (nbytes >= 4)
            return raw;
        mask = (32'd1 << (8 * nbytes)) - 32'd1;
        raw &= mask;
        if (raw[8 * nbytes - 1])
            raw |= ~mask;
        return raw;
    endfunction

    function automatic void reset_parser();
        pr_phase      = P_RIFF_TAG;
        pr_count      = 0;
        pr_shift      = '0;
        pr_rate       = '0;
        pr_bits       = '0;
        pr_chans      = '0;
        pr_skip_left  = '0;
        pr_data_left  = '0;
        pr_accum      = '0;
        pr_frame_byte = 0;
        pr_frame_idx  = '0;
        pr_halted     = 1'b0;
    endfunction

    // advance the parser by one accepted byte and queue the result it gives, if any
    function automatic void parse_wav_byte(logic [7:0] b, logic eof);
        wav_result_t r;
        logic        has_result;
        kind_t       kind;
        err_t        err;
        logic [31:0] sval;
        logic [31:0] fnum;
        logic        last;
        logic [31:0] v;
        int unsigned len;
        int unsigned q;
        int unsigned fb;

        if (pr_halted)
            return;
        has_result = 1'b0;
        kind = KIND_HEADER;
        err  = ERR_RIFF;
        sval = '0;
        fnum = '0;
        last = 1'b0;
        q  = pr_bits >> 3;
        fb = q * pr_chans;

        case (pr_phase)
            // skipping the body of an unknown chunk
            P_CHUNK_SKIP:
            begin
                pr_skip_left--;
                if (pr_skip_left == 0)
                    pr_phase = P_CHUNK_TAG;
            end
            // sample data, first channel only
            P_DATA:
            begin
                if (pr_frame_byte < q && pr_frame_byte < 4)
                    pr_accum |= 32'(b) << (8 * pr_frame_byte);
                pr_data_left--;
                pr_frame_byte++;
                if (pr_frame_byte >= fb)
                begin
                    has_result = 1'b1;
                    kind = KIND_SAMPLE;
                    sval = extend_sample(pr_accum, q);
                    fnum = pr_frame_idx;
                    last = (pr_data_left < fb);
                    pr_frame_idx++;
                    pr_frame_byte = 0;
                    pr_accum = '0;
                end
                if (pr_data_left == 0)
                    pr_halted = 1'b1;
            end
            // header fields, little-endian
            default:
            begin
                len = field_length(pr_phase);
                pr_shift = {b, pr_shift[31:8]};
                pr_count++;
                if (pr_count >= len)
                begin
                    v = (len <= 4) ? (pr_shift >> (8 * (4 - len))) : '0;
                    pr_count = 0;
                    case (pr_phase)
                        P_RIFF_TAG:
                            if (v != TAG_RIFF)
                            begin
                                has_result = 1'b1; kind = KIND_ERROR; err = ERR_RIFF;
                            end
                            else
                                pr_phase = P_RIFF_SIZE;
                        P_RIFF_SIZE:
                            pr_phase = P_WAVE_TAG;
                        P_WAVE_TAG:
                            if (v != TAG_WAVE)
                            begin
                                has_result = 1'b1; kind = KIND_ERROR; err = ERR_WAVE;
                            end
                            else
                                pr_phase = P_FMT_TAG;
                        P_FMT_TAG:
                            if (v != TAG_FMT)
                            begin
                                has_result = 1'b1; kind = KIND_ERROR; err = ERR_FMT_TAG;
                            end
                            else
                                pr_phase = P_FMT_SIZE;
                        P_FMT_SIZE:
                            if (v != FMT_CHUNK_SIZE)
                            begin
                                has_result = 1'b1; kind = KIND_ERROR; err = ERR_FMT_SIZE;
                            end
                            else
                                pr_phase = P_FORMAT_ID;
                        P_FORMAT_ID:
                            if (v != PCM_FORMAT_ID)
                            begin
                                has_result = 1'b1; kind = KIND_ERROR; err = ERR_FORMAT_ID;
                            end
                            else
                                pr_phase = P_CHANNELS;
                        P_CHANNELS:
                        begin
                            pr_chans = v[7:0];
                            pr_phase = P_RATE;
                        end
                        P_RATE:
                        begin
                            pr_rate  = v;
                            pr_phase = P_RATE_SKIP;
                        end
                        P_RATE_SKIP:
                            pr_phase = P_BITS;
                        P_BITS:
                        begin
                            pr_bits = v[7:0];
                            q = pr_bits >> 3;
                            if (pr_bits[2:0] != 0 || q == 0 || q > MAX_SAMPLE_BYTES
                                || pr_chans == 0)
                            begin
                                has_result = 1'b1; kind = KIND_ERROR; err = ERR_WIDTH;
                            end
                            else
                                pr_phase = P_CHUNK_TAG;
                        end
                        P_CHUNK_TAG:
                            pr_phase = (v == TAG_DATA) ? P_DATA_SIZE : P_CHUNK_SIZE;
                        P_CHUNK_SIZE:
                        begin
                            pr_skip_left = v;
                            pr_phase = (v == 0) ? P_CHUNK_TAG : P_CHUNK_SKIP;
                        end
                        default:
                        begin
                            pr_data_left  = v;
                            pr_frame_byte = 0;
                            pr_accum      = '0;
                            pr_frame_idx  = '0;
                            has_result    = 1'b1;
                            kind          = KIND_HEADER;
                            pr_phase      = P_DATA;
                            if (v == 0)
                                pr_halted = 1'b1;
                        end
                    endcase
                end
            end
        endcase

        if (has_result && kind == KIND_ERROR)
            pr_halted = 1'b1;
        // end of file before the parser is done
        if (eof && !pr_halted)
        begin
            has_result = 1'b1;
            kind = KIND_ERROR;
            err  = ERR_TRUNC;
            pr_halted = 1'b1;
        end
        if (!has_result)
            return;

        r = '{default: '0};
        r.kind = kind;
        if (kind == KIND_HEADER)
        begin
            r.rate       = pr_rate;
            r.bits       = pr_bits;
            r.chans      = pr_chans;
            r.data_bytes = pr_data_left;
        end
        else if (kind == KIND_SAMPLE)
        begin
            r.sample = sval;
            r.frame  = fnum;
            r.last   = last;
        end
        else
            r.err = err;
        parsed_results.push_back(r);
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    // result checker
    always @(posedge clk)
    begin
        wav_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (parsed_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual kind %0d",
                         $time, result_kind);
                mismatch_count++;
            end
            else
            begin
                want = parsed_results.pop_front();
                check_field("result_kind", 32'(want.kind), 32'(result_kind));
                check_field("sample_value", want.sample, sample_value);
                check_field("sample_rate", want.rate, sample_rate);
                check_field("bits_per_sample", 32'(want.bits), 32'(bits_per_sample));
                check_field("channel_count", 32'(want.chans), 32'(channel_count));
                check_field("data_byte_count", want.data_bytes, data_byte_count);
                check_field("frame_number", want.frame, frame_number);
                check_field("error_code", 32'(want.err), 32'(error_code));
                check_field("last_sample", 32'(want.last), 32'(last_sample));
            end
        end
    end

    // one byte request, with random sender gaps before it
    task automatic send_byte(input logic [7:0] b, input logic eof);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        byte_value  <= b;
        end_of_file <= eof;
        do
            @(posedge clk);
        while (in_stall);
        parse_wav_byte(b, eof);
    endtask

    task automatic send_word_le(input logic [31:0] w, input int unsigned nbytes);
        for (int i = 0; i < nbytes; i++)
            send_byte(w[8 * i +: 8], 1'b0);
    endtask

    task automatic send_random_bytes(input int unsigned n);
        for (int i = 0; i < n; i++)
            send_byte(8'($urandom_range(255)), 1'b0);
    endtask

    // one frame: the first channel's sample, then the other channels at random
    task automatic send_frame(input logic [31:0] first);
        send_word_le(first, sample_size);
        send_random_bytes(frame_size - sample_size);
    endtask

    // hold the sender off until every awaited result has come out
    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (parsed_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        stall_pct     = recv_pct;
    endtask

    task automatic test_riff_header();
        send_word_le(TAG_RIFF, 4);
        send_word_le($urandom, 4);
        send_word_le(TAG_WAVE, 4);
    endtask

    // fmt chunk with random layout; frames of at least three bytes leave room
    // for a partial frame of two bytes or more at the end
    task automatic test_fmt_chunk();
        sample_size   = $urandom_range(1, MAX_SAMPLE_BYTES);
        channel_total = $urandom_range(1, 4);
        if (sample_size * channel_total < 3)
            channel_total = 3;
        frame_size       = sample_size * channel_total;
        frames_per_phase = 250 / frame_size;
        send_word_le(TAG_FMT, 4);
        send_word_le(FMT_CHUNK_SIZE, 4);
        send_word_le(PCM_FORMAT_ID, 2);
        // only the low byte of channels and bit depth counts
        send_byte(8'(channel_total), 1'b0);
        send_byte(8'($urandom_range(255)), 1'b0);
        send_word_le($urandom, 4);
        send_random_bytes(6);
        send_byte(8'(8 * sample_size), 1'b0);
        send_byte(8'($urandom_range(255)), 1'b0);
    endtask

    task automatic test_skipped_chunks();
        logic [31:0] tag;
        int unsigned len;
        // empty chunk with a random tag
        tag = $urandom;
        if (tag == TAG_DATA)
            tag ^= 32'h1;
        send_word_le(tag, 4);
        send_word_le(32'd0, 4);
        // tag one letter off from data, body that holds the data tag
        len = $urandom_range(4, 20);
        send_word_le(TAG_DATA ^ 32'h0100_0000, 4);
        send_word_le(len, 4);
        send_word_le(TAG_DATA, 4);
        send_random_bytes(len - 4);
        // short chunk of random bytes
        len = $urandom_range(1, 12);
        send_word_le(32'h4b4e_554a, 4);
        send_word_le(len, 4);
        send_random_bytes(len);
    endtask

    // data chunk header, then the sample extremes
    task automatic test_extreme_samples();
        logic [31:0] data_bytes;
        logic [31:0] top;
        data_bytes = (4 + 4 * frames_per_phase) * frame_size + (frame_size - 1);
        send_word_le(TAG_DATA, 4);
        send_word_le(data_bytes, 4);
        set_idling(0, 0);
        top = 32'd1 << (8 * sample_size - 1);
        send_frame(top);
        send_frame(top - 32'd1);
        send_frame(32'd0);
        send_frame(32'hffff_ffff);
    endtask

    // random frames under each idling pattern, drained between patterns
    task automatic test_random_frames();
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: set_idling(0, 0);
                1: set_idling(78, 0);
                2: set_idling(0, 78);
                default: set_idling(9, 9);
            endcase
            wait_drained();
            for (int n = 0; n < frames_per_phase; n++)
                send_frame($urandom);
        end
    endtask

    // partial frame cut short by end of file, then bytes the halted parser ignores
    task automatic test_truncated_tail();
        int unsigned partial;
        set_idling(30, 30);
        partial = frame_size - 1;
        for (int i = 0; i < partial; i++)
            send_byte(8'($urandom_range(255)), i == partial - 2);
        for (int i = 0; i < 3; i++)
            send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
    endtask

    initial
    begin
        mismatch_count = 0;
        cycle_count    = 0;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        byte_value     = '0;
        end_of_file    = 1'b0;
        reset_parser();
        set_idling(50, 50);
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_riff_header();
        test_fmt_chunk();
        test_skipped_chunks();
        test_extreme_samples();
        test_random_frames();
        test_truncated_tail();

        wait_drained();
        end_of_file <= 1'b0;
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
